[hdl/source_text_tokenizer_defines.svh]
// Assertion macros shared by the tokenizer checker.
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define STT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tokenizer check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define STT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tokenizer check failed");

`endif

[hdl/stt_pkg.sv]
// Types, codes and lookup functions shared by the tokenizer files.
package stt_pkg;

	localparam int KEYWORD_BYTES_DEF = 8;
	localparam int POSITION_BITS_DEF = 16;
	localparam int KW_COUNT = 18;
	localparam int KW_MAX_LEN = 8;

	// status codes
	localparam logic [2:0] ST_TOKEN        = 3'd0;
	localparam logic [2:0] ST_BAD_CHAR     = 3'd1;
	localparam logic [2:0] ST_EXTRA_DOT    = 3'd2;
	localparam logic [2:0] ST_OPEN_STRING  = 3'd3;
	localparam logic [2:0] ST_OPEN_COMMENT = 3'd4;
	localparam logic [2:0] ST_LONE_BANG    = 3'd5;

	// token kinds named outside the lookup functions
	localparam logic [5:0] K_IDENT  = 6'd0;
	localparam logic [5:0] K_INT    = 6'd13;
	localparam logic [5:0] K_REAL   = 6'd14;
	localparam logic [5:0] K_STRING = 6'd15;
	localparam logic [5:0] K_CHAR   = 6'd16;
	localparam logic [5:0] K_ASSIGN = 6'd45;
	localparam logic [5:0] K_EQ     = 6'd46;
	localparam logic [5:0] K_NE     = 6'd47;
	localparam logic [5:0] K_LAST   = 6'd47;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} text_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  token_kind;
		logic [15:0] line_number;
		logic [15:0] start_column;
		logic [15:0] token_length;
		logic        last_result;
	} token_t;

	typedef struct packed {
		logic [5:0] kind;
		logic       two;
	} pair_t;

	// keyword spellings, first letter in the highest used byte
	localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
		64'("int"), 64'("string"), 64'("char"), 64'("real"), 64'("auto"),
		64'("bool"), 64'("return"), 64'("and"), 64'("or"), 64'("not"),
		64'("true"), 64'("while"), 64'("for"), 64'("if"), 64'("else"),
		64'("false"), 64'("break"), 64'("continue")
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd3, 4'd6, 4'd4, 4'd4, 4'd4, 4'd4, 4'd6, 4'd3, 4'd2,
		4'd3, 4'd4, 4'd5, 4'd3, 4'd2, 4'd4, 4'd5, 4'd5, 4'd8
	};
	localparam logic [5:0] KW_KIND [KW_COUNT] = '{
		6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd2, 6'd3, 6'd4,
		6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd12
	};

	function automatic logic is_alpha(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic [5:0] single_kind(input logic [7:0] b);
		case (b)
			"(": return 6'd17;
			")": return 6'd18;
			"[": return 6'd19;
			"]": return 6'd20;
			"{": return 6'd21;
			"}": return 6'd22;
			".": return 6'd23;
			",": return 6'd24;
			":": return 6'd25;
			";": return 6'd26;
			default: return 6'd0;
		endcase
	endfunction

	function automatic logic [5:0] oper_base(input logic [7:0] b);
		case (b)
			"+": return 6'd27;
			"-": return 6'd30;
			"*": return 6'd33;
			"/": return 6'd36;
			"%": return 6'd39;
			">": return 6'd41;
			"<": return 6'd43;
			default: return 6'd0;
		endcase
	endfunction

	// kind of an operator given its first byte and the byte after it
	function automatic pair_t op_pair(input logic [7:0] p, input logic [7:0] b);
		logic [5:0] base;
		logic       arith;
		pair_t      r;
		base  = oper_base(p);
		arith = base >= 6'd27 && base <= 6'd36;
		r.two = 1'b1;
		if (b == "=") begin
			r.kind = arith ? base + 6'd2 : base + 6'd1;
		end else if (b == p) begin
			r.kind = arith ? base + 6'd1 : base;
		end else begin
			r.kind = base;
			r.two  = 1'b0;
		end
		return r;
	endfunction

endpackage

[hdl/stt_keyword.sv]
// Keyword lookup over the first bytes of an identifier.
module stt_keyword (
	input  logic [stt_pkg::KW_MAX_LEN-1:0][7:0] window,
	input  logic [4:0]                          len,
	input  logic                                len_ok,
	output logic [5:0]                          kind
);

	logic hit;
	int   pos;

	// compare against every keyword of the same length
	always_comb begin
		kind = stt_pkg::K_IDENT;
		for (int k = 0; k < stt_pkg::KW_COUNT; k++) begin
			hit = len_ok && (len == {1'b0, stt_pkg::KW_LEN[k]});
			for (int i = 0; i < stt_pkg::KW_MAX_LEN; i++) begin
				pos = int'(stt_pkg::KW_LEN[k]) - 1 - i;
				if (pos >= 0) begin
					if (window[i] != stt_pkg::KW_TEXT[k][pos*8 +: 8]) begin
						hit = 1'b0;
					end
				end
			end
			if (hit) begin
				kind = stt_pkg::KW_KIND[k];
			end
		end
	end

endmodule

[hdl/source_text_tokenizer.sv]
// Source text tokenizer: one byte in per beat, up to three token results out.
//
// Takes one text byte per cycle while text_ready is high and updates the scanner
// state in the same cycle; the results caused by a byte (none to three) are held
// in a three-entry result stage and leave one per cycle while token_ready is high.
// A byte that causes more than one result holds the input, as text_ready drops
// until the last of them is being taken. After an error result the block accepts
// and drops every byte until arst_n is applied.
module source_text_tokenizer #(
	parameter int KEYWORD_BYTES = stt_pkg::KEYWORD_BYTES_DEF,
	parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            text_valid,
	output logic            text_ready,
	input  stt_pkg::text_t  text,
	output logic            token_valid,
	input  logic            token_ready,
	output stt_pkg::token_t token
);

	localparam int PB = POSITION_BITS;
	localparam int KI = (KEYWORD_BYTES > 1) ? $clog2(KEYWORD_BYTES) : 1;
	localparam logic [PB-1:0] POS_MAX = '1;

	typedef enum logic [3:0] {
		M_IDLE, M_IDENT, M_INT, M_FRAC, M_OPER, M_EQUAL, M_BANG,
		M_BSLASH, M_LINE, M_BLOCK, M_BLOCK_BS, M_STRING
	} mode_t;

	mode_t           mode_q, mode_n;
	logic [PB-1:0]   line_q, line_n, col_q, col_n, tstart_q, tstart_n, tbytes_q, tbytes_n;
	logic [7:0]      pend_q, pend_n, quote_q, quote_n;
	logic            halt_q, halt_n;
	logic [7:0]      win_q [KEYWORD_BYTES];
	logic            win_we;
	logic [KI-1:0]   win_idx;
	logic [stt_pkg::KW_MAX_LEN-1:0][7:0] win_cur, win_ext;
	logic [PB-1:0]   tbytes_inc;
	logic [5:0]      kw_cur, kw_fin;
	stt_pkg::token_t res [3];
	stt_pkg::token_t res_s1 [3];
	logic [1:0]      nres, cnt_s1;
	logic            again, take, give;
	logic [7:0]      b;
	stt_pkg::pair_t  pr;

	function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
		return (v != POS_MAX) ? v + PB'(1) : v;
	endfunction

	function automatic stt_pkg::token_t mk(input logic [2:0] st, input logic [5:0] k,
		input logic [PB-1:0] ln, input logic [PB-1:0] cl, input logic [PB-1:0] len);
		stt_pkg::token_t r;
		r.status       = st;
		r.token_kind   = k;
		r.line_number  = 16'(ln);
		r.start_column = 16'(cl);
		r.token_length = 16'(len);
		r.last_result  = 1'b0;
		return r;
	endfunction

	assign b          = text.text_byte;
	assign take       = text_valid && text_ready;
	assign give       = token_valid && token_ready;
	assign text_ready = (cnt_s1 == 2'd0) || (cnt_s1 == 2'd1 && token_ready);
	assign token_valid = cnt_s1 != 2'd0;
	assign token      = res_s1[0];
	assign tbytes_inc = sat_inc(tbytes_q);

	// present the stored window, and the window with this byte appended
	always_comb begin
		for (int i = 0; i < stt_pkg::KW_MAX_LEN; i++) begin
			win_cur[i] = win_q[i];
			win_ext[i] = win_q[i];
			if (tbytes_q == PB'(i)) begin
				win_ext[i] = b;
			end
		end
	end

	stt_keyword u_kw_cur (
		.window (win_cur),
		.len    (tbytes_q[4:0]),
		.len_ok (tbytes_q <= PB'(KEYWORD_BYTES)),
		.kind   (kw_cur)
	);

	stt_keyword u_kw_fin (
		.window (win_ext),
		.len    (tbytes_inc[4:0]),
		.len_ok (tbytes_inc <= PB'(KEYWORD_BYTES)),
		.kind   (kw_fin)
	);

	// scan one byte: next state and the results it causes
	always_comb begin
		mode_n   = mode_q;
		line_n   = line_q;
		col_n    = col_q;
		tstart_n = tstart_q;
		tbytes_n = tbytes_q;
		pend_n   = pend_q;
		quote_n  = quote_q;
		halt_n   = halt_q;
		win_we   = 1'b0;
		win_idx  = tbytes_q[KI-1:0];
		nres     = 2'd0;
		again    = 1'b0;
		pr       = stt_pkg::op_pair(pend_q, b);
		for (int i = 0; i < 3; i++) begin
			res[i] = mk(stt_pkg::ST_TOKEN, stt_pkg::K_IDENT, '0, '0, '0);
		end
		if (!halt_q) begin
			case (mode_q)
				M_IDENT: begin
					if (stt_pkg::is_alpha(b) || stt_pkg::is_digit(b)) begin
						win_we   = tbytes_q < PB'(KEYWORD_BYTES);
						tbytes_n = tbytes_inc;
					end else begin
						res[nres] = mk(stt_pkg::ST_TOKEN, kw_cur, line_q, tstart_q, tbytes_q);
						nres = nres + 2'd1;
						again = 1'b1;
					end
				end
				M_INT: begin
					if (stt_pkg::is_digit(b)) begin
						tbytes_n = tbytes_inc;
					end else if (b == ".") begin
						tbytes_n = tbytes_inc;
						mode_n   = M_FRAC;
					end else begin
						res[nres] = mk(stt_pkg::ST_TOKEN, stt_pkg::K_INT, line_q, tstart_q,
							tbytes_q);
						nres = nres + 2'd1;
						again = 1'b1;
					end
				end
				M_FRAC: begin
					if (stt_pkg::is_digit(b)) begin
						tbytes_n = tbytes_inc;
					end else if (b == ".") begin
						res[nres] = mk(stt_pkg::ST_EXTRA_DOT, stt_pkg::K_IDENT, line_q, col_q, '0);
						nres = nres + 2'd1;
						halt_n = 1'b1;
					end else begin
						res[nres] = mk(stt_pkg::ST_TOKEN, stt_pkg::K_REAL, line_q, tstart_q,
							tbytes_q);
						nres = nres + 2'd1;
						again = 1'b1;
					end
				end
				M_OPER: begin
					res[nres] = mk(stt_pkg::ST_TOKEN, pr.kind, line_q, tstart_q,
						pr.two ? PB'(2) : PB'(1));
					nres = nres + 2'd1;
					if (pr.two) begin
						mode_n = M_IDLE;
					end else begin
						again = 1'b1;
					end
				end
				M_EQUAL: begin
					if (b == "=") begin
						res[nres] = mk(stt_pkg::ST_TOKEN, stt_pkg::K_EQ, line_q, tstart_q, PB'(2));
						mode_n = M_IDLE;
					end else begin
						res[nres] = mk(stt_pkg::ST_TOKEN, stt_pkg::K_ASSIGN, line_q, tstart_q,
							PB'(1));
						again = 1'b1;
					end
					nres = nres + 2'd1;
				end
				M_BANG: begin
					if (b == "=") begin
						res[nres] = mk(stt_pkg::ST_TOKEN, stt_pkg::K_NE, line_q, tstart_q, PB'(2));
						mode_n = M_IDLE;
					end else begin
						res[nres] = mk(stt_pkg::ST_LONE_BANG, stt_pkg::K_IDENT, line_q, tstart_q,
							'0);
						halt_n = 1'b1;
					end
					nres = nres + 2'd1;
				end
				M_BSLASH: begin
					if (b == "(") begin
						mode_n = M_BLOCK;
					end else if (b == "\n") begin
						mode_n = M_IDLE;
					end else begin
						mode_n = M_LINE;
					end
				end
				M_LINE: begin
					if (b == "\n") begin
						mode_n = M_IDLE;
					end
				end
				M_BLOCK: begin
					if (b == "\\") begin
						mode_n = M_BLOCK_BS;
					end
				end
				M_BLOCK_BS: begin
					if (b == ")") begin
						mode_n = M_IDLE;
					end else if (b != "\\") begin
						mode_n = M_BLOCK;
					end
				end
				M_STRING: begin
					if (b == quote_q) begin
						res[nres] = mk(stt_pkg::ST_TOKEN,
							(quote_q == "\"") ? stt_pkg::K_STRING : stt_pkg::K_CHAR,
							line_q, tstart_q, tbytes_q);
						nres = nres + 2'd1;
						mode_n = M_IDLE;
					end else if (b == "\n") begin
						res[nres] = mk(stt_pkg::ST_OPEN_STRING, stt_pkg::K_IDENT, line_q,
							tstart_q, '0);
						nres = nres + 2'd1;
						halt_n = 1'b1;
					end else begin
						tbytes_n = tbytes_inc;
					end
				end
				default: begin
					again = 1'b1;
				end
			endcase

			// start whatever this byte opens between tokens
			if (again && !halt_n) begin
				mode_n = M_IDLE;
				if (stt_pkg::is_alpha(b)) begin
					mode_n   = M_IDENT;
					tstart_n = col_q;
					win_we   = 1'b1;
					win_idx  = '0;
					tbytes_n = PB'(1);
				end else if (stt_pkg::is_digit(b)) begin
					mode_n   = M_INT;
					tstart_n = col_q;
					tbytes_n = PB'(1);
				end else if (stt_pkg::single_kind(b) != 6'd0) begin
					res[nres] = mk(stt_pkg::ST_TOKEN, stt_pkg::single_kind(b), line_q, col_q,
						PB'(1));
					nres = nres + 2'd1;
				end else if (b == "\\") begin
					mode_n = M_BSLASH;
				end else if (stt_pkg::oper_base(b) != 6'd0) begin
					mode_n   = M_OPER;
					tstart_n = col_q;
					tbytes_n = '0;
					pend_n   = b;
				end else if (b == "=") begin
					mode_n   = M_EQUAL;
					tstart_n = col_q;
					tbytes_n = '0;
				end else if (b == "!") begin
					mode_n   = M_BANG;
					tstart_n = col_q;
					tbytes_n = '0;
				end else if (b == "\"" || b == "'") begin
					mode_n   = M_STRING;
					tstart_n = col_q;
					tbytes_n = '0;
					quote_n  = b;
				end else if (b == " " || b == "\t" || b == "\n") begin
					mode_n = M_IDLE;
				end else begin
					res[nres] = mk(stt_pkg::ST_BAD_CHAR, stt_pkg::K_IDENT, line_q, col_q, '0);
					nres = nres + 2'd1;
					halt_n = 1'b1;
				end
			end

			// close the pending token at end of text
			if (!halt_n && text.end_of_text) begin
				pr = stt_pkg::op_pair(pend_n, " ");
				case (mode_n)
					M_IDENT: begin
						res[nres] = mk(stt_pkg::ST_TOKEN,
							(mode_q == M_IDENT) ? kw_fin : stt_pkg::K_IDENT,
							line_q, tstart_n, tbytes_n);
						nres = nres + 2'd1;
					end
					M_INT: begin
						res[nres] = mk(stt_pkg::ST_TOKEN, stt_pkg::K_INT, line_q, tstart_n,
							tbytes_n);
						nres = nres + 2'd1;
					end
					M_FRAC: begin
						res[nres] = mk(stt_pkg::ST_TOKEN, stt_pkg::K_REAL, line_q, tstart_n,
							tbytes_n);
						nres = nres + 2'd1;
					end
					M_OPER: begin
						res[nres] = mk(stt_pkg::ST_TOKEN, pr.kind, line_q, tstart_n, PB'(1));
						nres = nres + 2'd1;
					end
					M_EQUAL: begin
						res[nres] = mk(stt_pkg::ST_TOKEN, stt_pkg::K_ASSIGN, line_q, tstart_n,
							PB'(1));
						nres = nres + 2'd1;
					end
					M_BANG: begin
						res[nres] = mk(stt_pkg::ST_LONE_BANG, stt_pkg::K_IDENT, line_q,
							tstart_n, '0);
						nres = nres + 2'd1;
						halt_n = 1'b1;
					end
					M_BLOCK, M_BLOCK_BS: begin
						res[nres] = mk(stt_pkg::ST_OPEN_COMMENT, stt_pkg::K_IDENT, line_q,
							col_q, '0);
						nres = nres + 2'd1;
						halt_n = 1'b1;
					end
					M_STRING: begin
						res[nres] = mk(stt_pkg::ST_OPEN_STRING, stt_pkg::K_IDENT, line_q,
							tstart_n, '0);
						nres = nres + 2'd1;
						halt_n = 1'b1;
					end
					default: begin
						nres = nres;
					end
				endcase
				if (!halt_n) begin
					mode_n   = M_IDLE;
					line_n   = PB'(1);
					col_n    = '0;
					tbytes_n = '0;
					pend_n   = '0;
				end
			end else if (!halt_n) begin
				// advance the position
				if (b == "\n") begin
					line_n = sat_inc(line_q);
					col_n  = '0;
				end else begin
					col_n = sat_inc(col_q);
				end
			end

			// mark the last result of this byte
			if (nres != 2'd0) begin
				res[nres - 2'd1].last_result = 1'b1;
			end
		end
	end

	// hold scanner state, advance on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			line_q   <= PB'(1);
			col_q    <= '0;
			tstart_q <= '0;
			tbytes_q <= '0;
			pend_q   <= '0;
			quote_q  <= '0;
			halt_q   <= 1'b0;
		end else if (take) begin
			mode_q   <= mode_n;
			line_q   <= line_n;
			col_q    <= col_n;
			tstart_q <= tstart_n;
			tbytes_q <= tbytes_n;
			pend_q   <= pend_n;
			quote_q  <= quote_n;
			halt_q   <= halt_n;
		end
	end

	// keyword window: first bytes of the current identifier
	always_ff @(posedge clk) begin
		if (take && win_we) begin
			win_q[win_idx] <= b;
		end
	end

	// result stage: load a byte's results, drop one per taken beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s1 <= 2'd0;
		end else if (take) begin
			cnt_s1 <= nres;
		end else if (give) begin
			cnt_s1 <= cnt_s1 - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_s1 <= res;
		end else if (give) begin
			res_s1[0] <= res_s1[1];
			res_s1[1] <= res_s1[2];
		end
	end

endmodule

[hdl/stt_checker.sv]
// Port-level checks on the tokenizer, bound to its top level.
`include "source_text_tokenizer_defines.svh"

module stt_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            text_valid,
	input logic            text_ready,
	input stt_pkg::text_t  text,
	input logic            token_valid,
	input logic            token_ready,
	input stt_pkg::token_t token
);

	// an error is always the last result of its byte and carries no kind or length
	`STT_ASSERT_IMP(err_shape, token_valid && token.status != stt_pkg::ST_TOKEN, token.token_kind == stt_pkg::K_IDENT && token.token_length == 16'd0 && token.last_result)

	// nothing follows a taken error until reset
	`STT_ASSERT_NEXT(err_halts, token_valid && token_ready && token.status != stt_pkg::ST_TOKEN, !token_valid)

	// tokens carry a known kind and a line counted from one
	`STT_ASSERT_IMP(tok_range, token_valid && token.status == stt_pkg::ST_TOKEN, token.token_kind <= stt_pkg::K_LAST && token.line_number != 16'd0)

	// a stalled result holds
	`STT_ASSERT_NEXT(out_hold, token_valid && !token_ready, token_valid && $stable(token))

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (.*);

[sim/source_text_tokenizer_test.sv]
// Testbench for the source text tokenizer: directed table and random text.
`timescale 1ns / 1ps

module source_text_tokenizer_test;
	import stt_pkg::*;

	// scanner modes of the predictor
	typedef enum int {
		SC_IDLE, SC_IDENT, SC_INT, SC_FRAC, SC_OPER, SC_EQUAL, SC_BANG,
		SC_BSLASH, SC_LINE, SC_BLOCK, SC_BLOCK_BS, SC_STRING
	} scan_e;

	localparam int POS_MAX = 65535;
	localparam int KW_WINDOW = 8;
	localparam logic [5:0] K_TYPE = 6'd1;
	localparam logic [5:0] K_LPAREN = 6'd17;
	localparam logic [5:0] K_RBRACE = 6'd22;
	localparam logic [5:0] K_PLUS = 6'd27;
	localparam logic [5:0] K_PERCENT = 6'd39;
	localparam string SINGLES = "()[]{}.,:;";
	localparam string OPERS = "+-*/%><";
	localparam string ALPHA = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";

	string kw_word [18] = '{"int", "string", "char", "real", "auto", "bool", "return",
		"and", "or", "not", "true", "while", "for", "if", "else", "false", "break",
		"continue"};
	int kw_group [18] = '{0, 0, 0, 0, 0, 0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 11};

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    text_valid = 1'b0;
	logic    text_ready;
	text_t   text = '0;
	logic    token_valid;
	logic    token_ready = 1'b0;
	token_t  token;

	source_text_tokenizer u_top (
		.clk(clk), .arst_n(arst_n),
		.text_valid(text_valid), .text_ready(text_ready), .text(text),
		.token_valid(token_valid), .token_ready(token_ready), .token(token)
	);

	always #10 clk = ~clk;

	// predictor state
	scan_e      mode = SC_IDLE;
	int         line_cnt = 1, col_cnt = 0, tok_start = 0, tok_len = 0;
	string      id_text = "";
	logic [7:0] pend = 0, quote = 0;
	bit         halted = 0;

	token_t     step_q[$];
	token_t     tokens_due[$];
	logic [7:0] seg_q[$];
	int         fails = 0;
	bit         quiet = 0;
	int         sink_stall = 0;

	function automatic int sat(int v);
		return v < POS_MAX ? v + 1 : v;
	endfunction

	function automatic bit alpha(logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
	endfunction

	function automatic bit digit(logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic int find(string s, logic [7:0] b);
		for (int i = 0; i < s.len(); i++)
			if (s[i] == b) return i;
		return -1;
	endfunction

	function automatic logic [5:0] oper_kind(logic [7:0] p);
		int i;
		i = find(OPERS, p);
		return i < 4 ? K_PLUS + 6'(3 * i) : K_PERCENT + 6'(2 * (i - 4));
	endfunction

	function automatic logic [5:0] word_kind();
		if (tok_len > KW_WINDOW) return K_IDENT;
		foreach (kw_word[i])
			if (kw_word[i].len() == tok_len && kw_word[i] == id_text)
				return K_TYPE + 6'(kw_group[i]);
		return K_IDENT;
	endfunction

	task automatic emit(logic [2:0] st, logic [5:0] kind, int col, int len);
		token_t t;
		t = '{st, kind, 16'(line_cnt), 16'(col), 16'(len), 1'b0};
		if (step_q.size() < 3) step_q.push_back(t);
	endtask

	task automatic halt(logic [2:0] st, int col);
		emit(st, K_IDENT, col, 0);
		halted = 1;
	endtask

	task automatic add_id(logic [7:0] b);
		if (tok_len < KW_WINDOW) id_text = {id_text, string'(b)};
		tok_len = sat(tok_len);
	endtask

	task automatic open_tok(scan_e m, int col);
		mode = m;
		tok_start = col;
		tok_len = 0;
		id_text = "";
	endtask

	// pair the pending operator byte with the next one
	task automatic close_oper(logic [7:0] b, output bit two);
		logic [5:0] base;
		bit arith;
		base = oper_kind(pend);
		arith = base <= K_PLUS + 6'd9;
		two = 1;
		if (b == "=") emit(ST_TOKEN, arith ? base + 6'd2 : base + 6'd1, tok_start, 2);
		else if (b == pend) emit(ST_TOKEN, arith ? base + 6'd1 : base, tok_start, 2);
		else begin
			emit(ST_TOKEN, base, tok_start, 1);
			two = 0;
		end
	endtask

	task automatic idle_byte(logic [7:0] b, int col);
		mode = SC_IDLE;
		if (alpha(b)) begin
			open_tok(SC_IDENT, col);
			add_id(b);
		end else if (digit(b)) begin
			open_tok(SC_INT, col);
			tok_len = 1;
		end else if (find(SINGLES, b) >= 0) emit(ST_TOKEN, K_LPAREN + 6'(find(SINGLES, b)), col, 1);
		else if (b == "\\") mode = SC_BSLASH;
		else if (find(OPERS, b) >= 0) begin
			open_tok(SC_OPER, col);
			pend = b;
		end else if (b == "=") open_tok(SC_EQUAL, col);
		else if (b == "!") open_tok(SC_BANG, col);
		else if (b == "\"" || b == "'") begin
			open_tok(SC_STRING, col);
			quote = b;
		end else if (!(b == " " || b == "\t" || b == "\n")) halt(ST_BAD_CHAR, col);
	endtask

	// work out the tokens caused by one accepted byte into step_q
	task automatic predict_tokens(logic [7:0] b, bit eot);
		int col;
		bit again, two;
		col = col_cnt;
		again = 0;
		step_q.delete();
		if (halted) return;
		case (mode)
			SC_IDENT: begin
				if (alpha(b) || digit(b)) add_id(b);
				else begin
					emit(ST_TOKEN, word_kind(), tok_start, tok_len);
					again = 1;
				end
			end
			SC_INT: begin
				if (digit(b)) tok_len = sat(tok_len);
				else if (b == ".") begin
					tok_len = sat(tok_len);
					mode = SC_FRAC;
				end else begin
					emit(ST_TOKEN, K_INT, tok_start, tok_len);
					again = 1;
				end
			end
			SC_FRAC: begin
				if (digit(b)) tok_len = sat(tok_len);
				else if (b == ".") halt(ST_EXTRA_DOT, col);
				else begin
					emit(ST_TOKEN, K_REAL, tok_start, tok_len);
					again = 1;
				end
			end
			SC_OPER: begin
				close_oper(b, two);
				if (two) mode = SC_IDLE;
				else again = 1;
			end
			SC_EQUAL: begin
				if (b == "=") begin
					emit(ST_TOKEN, K_EQ, tok_start, 2);
					mode = SC_IDLE;
				end else begin
					emit(ST_TOKEN, K_ASSIGN, tok_start, 1);
					again = 1;
				end
			end
			SC_BANG: begin
				if (b == "=") begin
					emit(ST_TOKEN, K_NE, tok_start, 2);
					mode = SC_IDLE;
				end else halt(ST_LONE_BANG, tok_start);
			end
			SC_BSLASH: mode = (b == "(") ? SC_BLOCK : (b == "\n") ? SC_IDLE : SC_LINE;
			SC_LINE: if (b == "\n") mode = SC_IDLE;
			SC_BLOCK: if (b == "\\") mode = SC_BLOCK_BS;
			SC_BLOCK_BS: begin
				if (b == ")") mode = SC_IDLE;
				else if (b != "\\") mode = SC_BLOCK;
			end
			SC_STRING: begin
				if (b == quote) begin
					emit(ST_TOKEN, quote == "\"" ? K_STRING : K_CHAR, tok_start, tok_len);
					mode = SC_IDLE;
				end else if (b == "\n") halt(ST_OPEN_STRING, tok_start);
				else tok_len = sat(tok_len);
			end
			default: again = 1;
		endcase
		if (again && !halted) idle_byte(b, col);

		// close whatever is open at the final byte
		if (!halted && eot) begin
			case (mode)
				SC_IDENT: emit(ST_TOKEN, word_kind(), tok_start, tok_len);
				SC_INT: emit(ST_TOKEN, K_INT, tok_start, tok_len);
				SC_FRAC: emit(ST_TOKEN, K_REAL, tok_start, tok_len);
				SC_OPER: close_oper(" ", two);
				SC_EQUAL: emit(ST_TOKEN, K_ASSIGN, tok_start, 1);
				SC_BANG: halt(ST_LONE_BANG, tok_start);
				SC_BLOCK, SC_BLOCK_BS: halt(ST_OPEN_COMMENT, col);
				SC_STRING: halt(ST_OPEN_STRING, tok_start);
				default: ;
			endcase
			if (!halted) begin
				mode = SC_IDLE;
				line_cnt = 1;
				col_cnt = 0;
				tok_len = 0;
				pend = 0;
			end
		end else if (!halted) begin
			if (b == "\n") begin
				line_cnt = sat(line_cnt);
				col_cnt = 0;
			end else col_cnt = sat(col_cnt);
		end
		if (step_q.size() > 0) step_q[step_q.size() - 1].last_result = 1'b1;
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// offer one byte; a typed row replaces the predicted tokens with its own
	task automatic send_byte(logic [7:0] b, bit eot, bit typed = 0, token_t want = '0);
		int g;
		g = quiet ? 0 : gap_len();
		if (g > 0) begin
			text_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		text <= '{b, eot};
		text_valid <= 1'b1;
		@(posedge clk);
		while (!text_ready) @(posedge clk);
		predict_tokens(b, eot);
		if (typed) tokens_due.push_back(want);
		else foreach (step_q[i]) tokens_due.push_back(step_q[i]);
	endtask

	task automatic send_text(string s, bit eot);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], eot && i == s.len() - 1);
	endtask

	task automatic report(string what, int got, int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		fails++;
	endtask

	// check each result beat against the oldest expected token
	always @(posedge clk) begin
		token_t w;
		if (token_valid && token_ready) begin
			if (tokens_due.size() == 0) report("unexpected token, kind", token.token_kind, -1);
			else begin
				w = tokens_due.pop_front();
				if (token.status !== w.status) report("status", token.status, w.status);
				if (token.token_kind !== w.token_kind) report("kind", token.token_kind, w.token_kind);
				if (token.line_number !== w.line_number)
					report("line", token.line_number, w.line_number);
				if (token.start_column !== w.start_column)
					report("column", token.start_column, w.start_column);
				if (token.token_length !== w.token_length)
					report("length", token.token_length, w.token_length);
				if (token.last_result !== w.last_result)
					report("last", token.last_result, w.last_result);
			end
		end
	end

	// stall the result side at random
	always @(posedge clk) begin
		if (!arst_n) token_ready <= 1'b0;
		else if (sink_stall > 0) begin
			sink_stall <= sink_stall - 1;
			token_ready <= 1'b0;
		end else begin
			token_ready <= 1'b1;
			if (!quiet && $urandom_range(0, 99) < 20) sink_stall <= gap_len();
		end
	end

	function automatic logic [7:0] any_but(logic [7:0] a, logic [7:0] c);
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == a || b == c);
		return b;
	endfunction

	// append one well-formed token, comment or whitespace byte with random content to seg_q
	task automatic make_token();
		int n;
		logic [7:0] q;
		case ($urandom_range(0, 11))
			0: begin
				seg_q.push_back(ALPHA[$urandom_range(0, ALPHA.len() - 1)]);
				n = $urandom_range(0, 11);
				repeat (n) seg_q.push_back($urandom_range(0, 3) == 0 ?
					8'("0" + $urandom_range(0, 9)) : ALPHA[$urandom_range(0, ALPHA.len() - 1)]);
			end
			1: begin
				n = $urandom_range(0, 17);
				for (int i = 0; i < kw_word[n].len(); i++) seg_q.push_back(kw_word[n][i]);
			end
			2, 3: begin
				repeat ($urandom_range(1, 4)) seg_q.push_back(8'("0" + $urandom_range(0, 9)));
				if ($urandom_range(0, 1)) begin
					seg_q.push_back(".");
					repeat ($urandom_range(0, 3)) seg_q.push_back(8'("0" + $urandom_range(0, 9)));
				end
			end
			4, 5: begin
				q = $urandom_range(0, 1) ? "\"" : "'";
				seg_q.push_back(q);
				repeat ($urandom_range(0, 6)) seg_q.push_back(any_but(q, "\n"));
				seg_q.push_back(q);
			end
			6: seg_q.push_back(SINGLES[$urandom_range(0, SINGLES.len() - 1)]);
			7: begin
				q = OPERS[$urandom_range(0, OPERS.len() - 1)];
				seg_q.push_back(q);
				case ($urandom_range(0, 2))
					0: seg_q.push_back(q);
					1: seg_q.push_back("=");
					default: ;
				endcase
			end
			8: begin
				seg_q.push_back($urandom_range(0, 1) ? "=" : "!");
				if (seg_q[$] == "!" || $urandom_range(0, 1)) seg_q.push_back("=");
			end
			9: begin
				seg_q.push_back("\\");
				if ($urandom_range(0, 1)) repeat ($urandom_range(1, 8))
					seg_q.push_back(any_but("\n", "("));
				seg_q.push_back("\n");
			end
			10: begin
				seg_q.push_back("\\");
				seg_q.push_back("(");
				repeat ($urandom_range(0, 8)) seg_q.push_back(any_but("\\", "\\"));
				repeat ($urandom_range(1, 3)) seg_q.push_back("\\");
				seg_q.push_back(")");
			end
			default: seg_q.push_back($urandom_range(0, 1) ? "\n" : "\t");
		endcase
	endtask

	typedef struct {
		string  txt;
		bit     eot;
		bit     typed;
		token_t want;
	} row_t;

	row_t dir_rows [] = '{
		'{"(", 1, 1, '{ST_TOKEN, K_LPAREN, 16'd1, 16'd0, 16'd1, 1'b1}},
		'{"}", 1, 1, '{ST_TOKEN, K_RBRACE, 16'd1, 16'd0, 16'd1, 1'b1}},
		'{"if while(", 0, 0, '0},
		'{" continuex  break", 0, 0, '0},
		'{" %%>><=**==!=", 0, 0, '0},
		'{" 1.5 42 ", 0, 0, '0},
		'{"\"a\\\"", 0, 0, '0},
		'{"'x' ''", 0, 0, '0},
		'{"\\(x\n\\\\)", 0, 0, '0},
		'{"\\ note\n\\\n", 0, 0, '0},
		'{"_Az9 -- -= ++ += // /= *= %= >= <", 1, 0, '0},
		'{"=", 1, 1, '{ST_TOKEN, K_ASSIGN, 16'd1, 16'd0, 16'd1, 1'b1}},
		'{"int string char real auto bool return and or not true false else for", 1, 0, '0}
	};

	initial begin
		int sent, n;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_rows[r]) begin
			for (int i = 0; i < dir_rows[r].txt.len(); i++) begin
				if (i == dir_rows[r].txt.len() - 1)
					send_byte(dir_rows[r].txt[i], dir_rows[r].eot, dir_rows[r].typed,
						dir_rows[r].want);
				else send_byte(dir_rows[r].txt[i], 0);
			end
		end

		// random well-formed text in segments, each closed by the final-byte flag
		sent = 0;
		while (sent < 220) begin
			seg_q.delete();
			n = $urandom_range(1, 12);
			repeat (n) begin
				make_token();
				if ($urandom_range(0, 3) != 0) seg_q.push_back($urandom_range(0, 2) == 0 ? "\n" : " ");
			end
			// a dot right after a real would be a second dot
			foreach (seg_q[i]) begin
				if (i > 0 && seg_q[i] == "." && seg_q[i - 1] != " " && seg_q[i - 1] != "\n")
					seg_q[i] = ",";
			end
			foreach (seg_q[i]) send_byte(seg_q[i], i == seg_q.size() - 1);
			sent += seg_q.size();
			if ($urandom_range(0, 7) == 0) quiet = !quiet;
		end
		quiet = 0;

		// one error to close the run, then bytes that must be dropped
		send_byte(" ", 0);
		case ($urandom_range(0, 4))
			0: send_byte($urandom_range(0, 1) ? 8'($urandom_range(128, 255)) : 8'h00, 0);
			1: send_text("7.1.", 0);
			2: send_text("\"ab\n", 0);
			3: send_text("\\(ab", 1);
			default: send_text("!x", 0);
		endcase
		repeat (8) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 1));
		text_valid <= 1'b0;

		while (tokens_due.size() > 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fails == 0 && tokens_due.size() == 0) $display("source_text_tokenizer_test passed");
		else $display("source_text_tokenizer_test failed");
		$finish;
	end

	// end a run that has hung
	initial begin
		#60ms;
		$display("source_text_tokenizer_test failed");
		$finish;
	end

endmodule
